// ===== hdl/aecb_pkg.sv =====
// Package for the alpha edge colour bleed block.
// Command and status types shared by the controller and the datapath, plus op codes, register indices and reset values.
// No dependencies.
package aecb_pkg;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [1:0] REG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	localparam int CFG_W = 12;
	localparam logic [11:0] RST_WIDTH     = 12'd2048;
	localparam logic [11:0] RST_HEIGHT    = 12'd2048;
	localparam logic [7:0]  RST_THRESHOLD = 8'd20;

	typedef struct packed {
		logic wr_px;      // store incoming pixel, advance input position
		logic rd_center;  // read the pixel due for output
		logic scan_init;  // latch centre, set up the window scan
		logic rd_cand;    // read the next window candidate
		logic eval_cand;  // compare the candidate just read
		logic load_ctr;   // load the output with the centre pixel
		logic load_scan;  // load the output with the scan winner
		logic pop_out;    // result taken, advance output position
	} dp_cmd_t;

	typedef struct packed {
		logic in_done;
		logic emit_due;
		logic ctr_opaque;
		logic scan_last;
	} dp_stat_t;

endpackage

// ===== hdl/aecb_datapath.sv =====
// Datapath of the alpha edge colour bleed block: line store, position
// counters, window scan and output register. Depends on aecb_pkg.
module aecb_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int RADIUS     = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [aecb_pkg::CFG_W-1:0] cfg_wdata,
	input  logic [31:0]              px_in,
	input  aecb_pkg::dp_cmd_t        cmd,
	output aecb_pkg::dp_stat_t       stat,
	output logic [31:0]              out_data,
	output logic                     out_last,
	output logic                     out_valid
);
	import aecb_pkg::*;

	localparam int RING = 2 * RADIUS + 2;
	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int GW   = $clog2(RING);
	localparam int AW   = $clog2(RING * MAX_WIDTH);
	localparam int PW   = $clog2((RADIUS + 1) * MAX_WIDTH + 2);
	localparam int DW   = $clog2(RADIUS + 1);
	localparam int SW   = $clog2(2 * RADIUS * RADIUS + 1);

	logic [CFG_W-1:0] w_cfg_q, h_cfg_q;
	logic [7:0]       thr_q;
	logic [CW-1:0]    w_eff;
	logic [RW-1:0]    h_eff;

	logic [CW-1:0] ic_q, oc_q;
	logic [RW-1:0] ir_q, or_q;
	logic [GW-1:0] ig_q, og_q;
	logic [PW-1:0] pend_q;
	logic [PW-1:0] lead;
	logic          restart;

	logic [31:0] mem [RING * MAX_WIDTH];
	logic [31:0] rd_q;
	logic        mem_rd;
	logic [AW-1:0] raddr, waddr;

	logic [31:0]   ctr_q;
	logic [RW-1:0] k_q, r1_q;
	logic [CW-1:0] l_q, c0_q, c1_q;
	logic [GW-1:0] kg_q;
	logic [RW:0]   r0_w, r1_w;
	logic [CW:0]   c0_w, c1_w;
	logic [GW-1:0] diff, kg0;
	logic [DW-1:0] dy, dx;
	logic [SW-1:0] sq_dist;
	logic [SW-1:0] d_s1, best_q;
	logic          last_s1, found_q, take;
	logic [23:0]   rgb_q;
	logic [31:0]   out_q;
	logic          last_q, valid_q;
	logic          frame_last;

	always_comb begin
		if (w_cfg_q == '0)
			w_eff = CW'(1);
		else if (32'(w_cfg_q) > MAX_WIDTH)
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(w_cfg_q);
		if (h_cfg_q == '0)
			h_eff = RW'(1);
		else if (32'(h_cfg_q) > MAX_HEIGHT)
			h_eff = RW'(MAX_HEIGHT);
		else
			h_eff = RW'(h_cfg_q);
	end

	assign lead    = PW'(RADIUS) * PW'(w_eff) + PW'(RADIUS);
	assign restart = (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
		|| (cmd.pop_out && last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q <= RST_WIDTH;
			h_cfg_q <= RST_HEIGHT;
			thr_q   <= RST_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:     w_cfg_q <= cfg_wdata;
				REG_HEIGHT:    h_cfg_q <= cfg_wdata;
				REG_THRESHOLD: thr_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input and output positions, ring rows and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0; ir_q <= '0; ig_q <= '0;
			oc_q <= '0; or_q <= '0; og_q <= '0;
			pend_q <= '0;
		end else if (restart) begin
			ic_q <= '0; ir_q <= '0; ig_q <= '0;
			oc_q <= '0; or_q <= '0; og_q <= '0;
			pend_q <= '0;
		end else if (cmd.wr_px) begin
			pend_q <= pend_q + PW'(1);
			if (ic_q == w_eff - CW'(1)) begin
				ic_q <= '0;
				ir_q <= ir_q + RW'(1);
				ig_q <= (ig_q == GW'(RING - 1)) ? '0 : ig_q + GW'(1);
			end else begin
				ic_q <= ic_q + CW'(1);
			end
		end else if (cmd.pop_out) begin
			pend_q <= pend_q - PW'(1);
			if (oc_q == w_eff - CW'(1)) begin
				oc_q <= '0;
				or_q <= or_q + RW'(1);
				og_q <= (og_q == GW'(RING - 1)) ? '0 : og_q + GW'(1);
			end else begin
				oc_q <= oc_q + CW'(1);
			end
		end
	end

	assign waddr  = AW'(ig_q) * AW'(MAX_WIDTH) + AW'(ic_q);
	assign raddr  = cmd.rd_center ? AW'(og_q) * AW'(MAX_WIDTH) + AW'(oc_q)
		: AW'(kg_q) * AW'(MAX_WIDTH) + AW'(l_q);
	assign mem_rd = cmd.rd_center || cmd.rd_cand;

	always_ff @(posedge clk) begin
		if (cmd.wr_px)
			mem[waddr] <= px_in;
		if (mem_rd)
			rd_q <= mem[raddr];
	end

	// window bounds, clipped at the image edges
	always_comb begin
		r0_w = (or_q > RW'(RADIUS)) ? {1'b0, or_q} - (RW + 1)'(RADIUS) : '0;
		r1_w = ({1'b0, or_q} + (RW + 1)'(RADIUS) < {1'b0, h_eff})
			? {1'b0, or_q} + (RW + 1)'(RADIUS) : {1'b0, h_eff} - (RW + 1)'(1);
		c0_w = (oc_q > CW'(RADIUS)) ? {1'b0, oc_q} - (CW + 1)'(RADIUS) : '0;
		c1_w = ({1'b0, oc_q} + (CW + 1)'(RADIUS) < {1'b0, w_eff})
			? {1'b0, oc_q} + (CW + 1)'(RADIUS) : {1'b0, w_eff} - (CW + 1)'(1);
		diff = GW'(or_q - RW'(r0_w));
		kg0  = (og_q >= diff) ? og_q - diff : og_q + GW'(RING) - diff;
		dy   = DW'((k_q > or_q) ? k_q - or_q : or_q - k_q);
		dx   = DW'((l_q > oc_q) ? l_q - oc_q : oc_q - l_q);
		sq_dist = SW'(dy * dy) + SW'(dx * dx);
	end

	assign take = (rd_q[31:24] >= thr_q) && (!found_q || d_s1 < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_init) begin
			found_q <= 1'b0;
		end else if (cmd.eval_cand && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			ctr_q <= rd_q;
			rgb_q <= rd_q[23:0];
			k_q   <= RW'(r0_w);
			r1_q  <= RW'(r1_w);
			l_q   <= CW'(c0_w);
			c0_q  <= CW'(c0_w);
			c1_q  <= CW'(c1_w);
			kg_q  <= kg0;
		end
		if (cmd.rd_cand) begin
			d_s1    <= sq_dist;
			last_s1 <= (k_q == r1_q) && (l_q == c1_q);
			if (l_q == c1_q) begin
				l_q  <= c0_q;
				k_q  <= k_q + RW'(1);
				kg_q <= (kg_q == GW'(RING - 1)) ? '0 : kg_q + GW'(1);
			end else begin
				l_q <= l_q + CW'(1);
			end
		end
		if (cmd.eval_cand && take) begin
			best_q <= d_s1;
			rgb_q  <= rd_q[23:0];
		end
	end

	assign frame_last = (oc_q == w_eff - CW'(1)) && (or_q == h_eff - RW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load_ctr) begin
			out_q  <= rd_q;
			last_q <= frame_last;
		end else if (cmd.load_scan) begin
			out_q  <= {ctr_q[31:24], take ? rd_q[23:0] : rgb_q};
			last_q <= frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.load_ctr || cmd.load_scan)
			valid_q <= 1'b1;
		else if (cmd.pop_out)
			valid_q <= 1'b0;
	end

	assign stat.in_done    = (ir_q >= h_eff);
	assign stat.emit_due   = (ir_q >= h_eff) || (pend_q > lead);
	assign stat.ctr_opaque = (rd_q[31:24] >= thr_q);
	assign stat.scan_last  = last_s1;
	assign out_data  = out_q;
	assign out_last  = last_q;
	assign out_valid = valid_q;

	// the fill level never runs more than one past the output lead
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= lead + PW'(1))
		else $error("fill level beyond lead");
endmodule

// ===== hdl/aecb_ctrl.sv =====
// Controller of the alpha edge colour bleed block: sequences storing,
// the centre read and the window scan. Depends on aecb_pkg.
module aecb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  logic               out_ready,
	input  aecb_pkg::dp_stat_t stat,
	output aecb_pkg::dp_cmd_t  cmd
);
	import aecb_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_CENTER = 7'b0000100,
		S_CWAIT  = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_SWAIT  = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (in_op == OP_PIXEL && !stat.in_done) begin
						cmd.wr_px = 1'b1;
						state_d   = S_DECIDE;
					end else if (stat.in_done) begin
						state_d = S_CENTER;
					end
				end
			end
			S_DECIDE: state_d = stat.emit_due ? S_CENTER : S_IDLE;
			S_CENTER: begin
				cmd.rd_center = 1'b1;
				state_d       = S_CWAIT;
			end
			S_CWAIT: begin
				if (stat.ctr_opaque) begin
					cmd.load_ctr = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_cand = 1'b1;
				state_d     = S_SWAIT;
			end
			S_SWAIT: begin
				cmd.eval_cand = 1'b1;
				if (stat.scan_last) begin
					cmd.load_scan = 1'b1;
					state_d       = S_OUT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.pop_out = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

// ===== hdl/alpha_edge_color_bleed.sv =====
// Alpha edge colour bleed: takes one RGBA pixel per request in raster order
// and returns each pixel RADIUS rows plus RADIUS pixels later, a transparent
// one carrying the colour of its nearest opaque neighbour within the window.
// One request is handled at a time. A pixel that only fills the line store
// passes the idle and decide states; a result needs the centre read and,
// for a transparent centre, a read and a compare per pixel of the clipped
// window (up to (2*RADIUS+1)^2), scanned through the single line-store read
// port. Geometry writes restart the frame; drain requests flush pending
// pixels at frame end. Depends on aecb_pkg, aecb_ctrl and aecb_datapath.
module alpha_edge_color_bleed #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int RADIUS     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_alpha, in_red, in_green, in_blue
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_alpha, out_red, out_green, out_blue
	output logic        m_tlast
);
	import aecb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	aecb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	aecb_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.RADIUS     (RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.px_in     (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_valid (m_tvalid)
	);

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request taken while a result waits");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without being taken");
endmodule
